@@ rtl/qrzz_pkg.sv @@
// Shared constants, codes and types of the QR codeword zigzag reader.
package qrzz_pkg;

    localparam int DEF_MAX_DIM = 177;

    localparam int DIM_W   = 8;
    localparam int COUNT_W = 12;
    localparam int WORD_W  = 8;
    localparam int CFG_W   = 12;

    localparam logic [DIM_W-1:0] MIN_DIM      = 8'd21;
    localparam logic [DIM_W-1:0] RESET_DIM    = 8'd21;
    localparam logic [COUNT_W-1:0] RESET_TOTAL = 12'd26;
    localparam logic [1:0]       DIM_MOD_MASK = 2'b11;
    localparam logic [DIM_W-1:0] SKIP_COLUMN  = 8'd6;
    localparam logic [2:0]       LAST_BIT_POS = 3'd7;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // register indexes
    localparam logic REG_DIMENSION = 1'b0;
    localparam logic REG_TOTAL     = 1'b1;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [1:0] STAT_BAD_DIM   = 2'd2;
    localparam logic [1:0] STAT_PAST_END  = 2'd3;

    // memory entry layout
    localparam int ENTRY_MODULE   = 0;
    localparam int ENTRY_RESERVED = 1;

    typedef struct packed {
        logic             restart;
        logic             step;
        logic [DIM_W-1:0] restart_dim;
    } walk_ctrl_t;

endpackage

@@ rtl/qrzz_mem.sv @@
// Module matrix store: one write port, one registered read port.
module qrzz_mem #(
    parameter int MAX_DIM = qrzz_pkg::DEF_MAX_DIM,
    localparam int DEPTH  = MAX_DIM * MAX_DIM,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [1:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [1:0]        rdata
);
    import qrzz_pkg::*;

    logic [1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/qrzz_walk.sv @@
// Zigzag walk position: column pair, row counter, direction and read address.
module qrzz_walk #(
    parameter int MAX_DIM = qrzz_pkg::DEF_MAX_DIM,
    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  qrzz_pkg::walk_ctrl_t     ctrl,
    input  logic [qrzz_pkg::DIM_W-1:0] dimension,
    output logic [ADDR_W-1:0]        rd_addr,
    output logic                     finished
);
    import qrzz_pkg::*;

    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] cnt_reg, cnt_next;
    logic             half_reg, half_next;
    logic             up_reg, up_next;
    logic             fin_reg, fin_next;

    logic [DIM_W-1:0] x;
    logic [DIM_W-1:0] y;
    logic [DIM_W:0]   cnt_inc;
    logic [DIM_W-1:0] col_dec;

    always_comb
    begin
        x       = col_reg - {{(DIM_W-1){1'b0}}, half_reg};
        y       = up_reg ? (dimension - 8'd1 - cnt_reg) : cnt_reg;
        rd_addr = ADDR_W'(y) * ADDR_W'(MAX_DIM) + ADDR_W'(x);
    end

    always_comb
    begin
        col_next  = col_reg;
        cnt_next  = cnt_reg;
        half_next = half_reg;
        up_next   = up_reg;
        fin_next  = fin_reg;
        cnt_inc   = {1'b0, cnt_reg} + 9'd1;
        col_dec   = col_reg - 8'd2;
        if (ctrl.restart)
        begin
            col_next  = ctrl.restart_dim - 8'd1;
            cnt_next  = '0;
            half_next = 1'b0;
            up_next   = 1'b1;
            fin_next  = 1'b0;
        end
        else if (ctrl.step)
        begin
            if (!half_reg)
            begin
                half_next = 1'b1;
            end
            else
            begin
                half_next = 1'b0;
                cnt_next  = cnt_inc[DIM_W-1:0];
                if (cnt_inc >= {1'b0, dimension})
                begin
                    cnt_next = '0;
                    up_next  = ~up_reg;
                    if (col_reg <= 8'd2)
                    begin
                        fin_next = 1'b1;
                    end
                    else if (col_dec == SKIP_COLUMN)
                    begin
                        col_next = col_dec - 8'd1;
                    end
                    else
                    begin
                        col_next = col_dec;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= RESET_DIM - 8'd1;
            cnt_reg  <= '0;
            half_reg <= 1'b0;
            up_reg   <= 1'b1;
            fin_reg  <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            cnt_reg  <= cnt_next;
            half_reg <= half_next;
            up_reg   <= up_next;
            fin_reg  <= fin_next;
        end
    end

    assign finished = fin_reg;

endmodule

@@ rtl/qr_codeword_zigzag_reader_top.sv @@
// Top level of the QR codeword zigzag reader: control, byte packing and result word.
// Write command: stored at the accepting edge; busy stays low, no result.
// Read command: a checked read stays busy while one codeword is gathered; one module is read
// from the matrix store per cycle until the byte closes or the walk ends; reads are registered.
// Error results (bad dimension, past count) appear the cycle after start; busy stays low.
// Reset clears control and walk state, dimension 21, total 26; the matrix store is not cleared.
module qr_codeword_zigzag_reader_top #(
    parameter int MAX_DIM = qrzz_pkg::DEF_MAX_DIM
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [qrzz_pkg::CFG_W-1:0]   cfg_data,
    // command side
    input  logic                         start,
    output logic                         busy,
    input  logic                         command,
    input  logic [qrzz_pkg::DIM_W-1:0]   column,
    input  logic [qrzz_pkg::DIM_W-1:0]   row,
    input  logic                         module_bit,
    input  logic                         reserved_bit,
    // result side, one-cycle strobe
    output logic                         valid,
    output logic [qrzz_pkg::WORD_W-1:0]  codeword,
    output logic [qrzz_pkg::COUNT_W-1:0] codeword_index,
    output logic                         last,
    output logic [1:0]                   status
);
    import qrzz_pkg::*;

    localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // configuration registers
    logic [DIM_W-1:0]   dim_reg, dim_next;
    logic [COUNT_W-1:0] total_reg, total_next;

    // control state
    logic               state_reg, state_next;
    logic               pending_reg, pending_next;
    logic [2:0]         gathered_reg, gathered_next;
    logic [WORD_W-1:0]  shift_reg, shift_next;
    logic [COUNT_W-1:0] given_reg, given_next;

    // result word
    logic               valid_reg, valid_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [COUNT_W-1:0] index_reg, index_next;
    logic               last_reg, last_next;
    logic [1:0]         status_reg, status_next;

    logic               accept;
    logic               wr_item;
    logic               cfg_hit;
    logic               dim_ok;
    logic               in_range;
    logic               take;
    logic               complete;
    logic               issue;
    logic [COUNT_W-1:0] given_inc;

    walk_ctrl_t         walk_ctrl;
    logic               walk_finished;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [1:0]         rd_data;

    assign busy    = (state_reg == ST_RUN);
    assign accept  = start && !busy;
    assign wr_item = accept && (command == CMD_WRITE);
    // every register write restarts the walk; the index port only spans the two registers
    assign cfg_hit = cfg_wr_en;

    assign dim_ok = (dim_reg >= MIN_DIM) && ((dim_reg[1:0] & DIM_MOD_MASK) == 2'b01) &&
                    (dim_reg <= DIM_W'(MAX_DIM));

    // drop writes that fall outside the store, but still restart the walk
    assign in_range = (column < DIM_W'(MAX_DIM)) && (row < DIM_W'(MAX_DIM));
    assign wr_addr  = ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(column);

    // a data module arrives from the store in the cycle after its address was issued
    assign take      = pending_reg && !rd_data[ENTRY_RESERVED];
    assign complete  = take && (gathered_reg == LAST_BIT_POS);
    // hold the walk on the cycle that closes the byte: no read is issued then
    assign issue     = (state_reg == ST_RUN) && !walk_finished && !complete;
    assign given_inc = given_reg + 12'd1;

    always_comb
    begin
        walk_ctrl.restart     = wr_item || cfg_hit;
        walk_ctrl.step        = issue;
        walk_ctrl.restart_dim = (cfg_wr_en && (cfg_index == REG_DIMENSION)) ?
                                cfg_data[DIM_W-1:0] : dim_reg;
    end

    always_comb
    begin
        dim_next      = dim_reg;
        total_next    = total_reg;
        state_next    = state_reg;
        pending_next  = issue;
        gathered_next = gathered_reg;
        shift_next    = shift_reg;
        given_next    = given_reg;
        valid_next    = 1'b0;
        word_next     = word_reg;
        index_next    = index_reg;
        last_next     = 1'b0;
        status_next   = status_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DIMENSION: dim_next   = cfg_data[DIM_W-1:0];
                REG_TOTAL:     total_next = cfg_data[COUNT_W-1:0];
                default:       dim_next   = dim_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (wr_item || cfg_hit)
                begin
                    gathered_next = '0;
                    shift_next    = '0;
                    given_next    = '0;
                end
                else if (accept && (command == CMD_READ))
                begin
                    if (!dim_ok)
                    begin
                        valid_next  = 1'b1;
                        word_next   = '0;
                        index_next  = given_reg;
                        status_next = STAT_BAD_DIM;
                    end
                    else if (given_reg >= total_reg)
                    begin
                        valid_next  = 1'b1;
                        word_next   = '0;
                        index_next  = given_reg;
                        status_next = STAT_PAST_END;
                    end
                    else
                    begin
                        state_next    = ST_RUN;
                        gathered_next = '0;
                        shift_next    = '0;
                    end
                end
            end
            ST_RUN:
            begin
                if (complete)
                begin
                    valid_next    = 1'b1;
                    word_next     = {shift_reg[WORD_W-2:0], rd_data[ENTRY_MODULE]};
                    index_next    = given_reg;
                    last_next     = (given_inc == total_reg);
                    status_next   = STAT_OK;
                    given_next    = given_inc;
                    gathered_next = '0;
                    shift_next    = '0;
                    state_next    = ST_IDLE;
                end
                else if (take)
                begin
                    shift_next    = {shift_reg[WORD_W-2:0], rd_data[ENTRY_MODULE]};
                    gathered_next = gathered_reg + 3'd1;
                end
                else if (!pending_reg && walk_finished)
                begin
                    // walk ran out: drop the partial byte
                    valid_next    = 1'b1;
                    word_next     = '0;
                    index_next    = given_reg;
                    status_next   = STAT_EXHAUSTED;
                    gathered_next = '0;
                    shift_next    = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg      <= RESET_DIM;
            total_reg    <= RESET_TOTAL;
            state_reg    <= ST_IDLE;
            pending_reg  <= 1'b0;
            gathered_reg <= '0;
            shift_reg    <= '0;
            given_reg    <= '0;
            valid_reg    <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            dim_reg      <= dim_next;
            total_reg    <= total_next;
            state_reg    <= state_next;
            pending_reg  <= pending_next;
            gathered_reg <= gathered_next;
            shift_reg    <= shift_next;
            given_reg    <= given_next;
            valid_reg    <= valid_next;
            last_reg     <= last_next;
        end
    end

    // payload of the result word needs no reset
    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        index_reg  <= index_next;
        status_reg <= status_next;
    end

    assign valid          = valid_reg;
    assign codeword       = word_reg;
    assign codeword_index = index_reg;
    assign last           = last_reg;
    assign status         = status_reg;

    qrzz_walk #(
        .MAX_DIM (MAX_DIM)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (walk_ctrl),
        .dimension (dim_reg),
        .rd_addr   (rd_addr),
        .finished  (walk_finished)
    );

    qrzz_mem #(
        .MAX_DIM (MAX_DIM)
    ) u_mem (
        .clk   (clk),
        .we    (wr_item && in_range),
        .waddr (wr_addr),
        .wdata ({reserved_bit, module_bit}),
        .re    (issue),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // a store read is only in flight while a codeword is being gathered
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> state_reg == ST_RUN)
        else $error("store read outstanding outside a codeword read");

    // partial bytes never survive the end of a read
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (gathered_reg == 3'd0 && shift_reg == '0))
        else $error("partial byte left over in idle");

    // error results carry a zero codeword and never flag last
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg != STAT_OK) |-> (word_reg == '0 && !last_reg))
        else $error("error result with codeword or last set");

    // a good codeword advances the count by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && status_reg == STAT_OK) |-> given_reg == index_reg + 12'd1)
        else $error("codeword count did not follow a good codeword");

endmodule
